// File: rtl/core/kld_pkg.sv
// ----------------------------------------------------------------------------
// kld_pkg: shared types and constants for the KL divergence accumulator
// Fraction table for the log2 approximation, plane codes, register indexes.
// ----------------------------------------------------------------------------
package kld_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int INDEX_WIDTH  = 6;
   localparam int BINS_WIDTH   = 7;
   localparam int PLANE_WIDTH  = 2;
   localparam int LOGK_WIDTH   = 4;
   localparam int FRAC_WIDTH   = 9;
   localparam int FRAC_BITS    = 6;
   localparam int FRAC_SHIFT   = 9;
   localparam int FRAC_STEPS   = 64;
   localparam int TERM_WIDTH   = 21;
   localparam int DELTA_WIDTH  = TERM_WIDTH + 1;
   localparam int SUM_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH = BINS_WIDTH;

   // effective bin count saturates here
   localparam logic [BINS_WIDTH-1:0] MAX_BINS = 7'd64;
   localparam logic [BINS_WIDTH-1:0] BIN_COUNT_RESET = 7'd64;

   typedef enum logic [PLANE_WIDTH-1:0] {
      PLANE_ALL   = 2'd0,
      PLANE_LEFT  = 2'd1,
      PLANE_RIGHT = 2'd2
   } plane_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PLANE_MODE = 1'd0,
      CSR_BIN_COUNT  = 1'd1
   } csr_index_type;

   // log2(x) ~ k + frac/512, frac is zero for an exact power of two
   typedef struct packed {
      logic [LOGK_WIDTH-1:0] k;
      logic [FRAC_WIDTH-1:0] frac;
   } log_parts_type;

   // control that travels with a beat into the accumulator
   typedef struct packed {
      logic valid;
      logic last;
   } beat_type;

   localparam logic [FRAC_WIDTH-1:0] FRAC_LOG [FRAC_STEPS] = '{
      9'd11,  9'd22,  9'd33,  9'd44,  9'd54,  9'd65,  9'd75,  9'd85,
      9'd95,  9'd105, 9'd115, 9'd125, 9'd134, 9'd144, 9'd153, 9'd162,
      9'd171, 9'd180, 9'd189, 9'd198, 9'd206, 9'd215, 9'd223, 9'd232,
      9'd240, 9'd248, 9'd256, 9'd264, 9'd272, 9'd280, 9'd288, 9'd295,
      9'd303, 9'd310, 9'd318, 9'd325, 9'd332, 9'd340, 9'd347, 9'd354,
      9'd361, 9'd368, 9'd375, 9'd381, 9'd388, 9'd395, 9'd401, 9'd408,
      9'd414, 9'd421, 9'd427, 9'd434, 9'd440, 9'd446, 9'd452, 9'd459,
      9'd465, 9'd471, 9'd477, 9'd483, 9'd488, 9'd494, 9'd500, 9'd506
   };

endpackage

// File: rtl/core/kld_log_decode.sv
// ----------------------------------------------------------------------------
// kld_log_decode: log2 decomposition of one 16-bit count
// Leading-one position plus table fraction indexed by the bits below it.
// ----------------------------------------------------------------------------
module kld_log_decode
   import kld_pkg::*;
(
   input  logic [COUNT_WIDTH-1:0] x,
   output log_parts_type          parts
);

   logic [LOGK_WIDTH-1:0]            lead;
   logic [COUNT_WIDTH-1:0]           rest;
   logic [COUNT_WIDTH+FRAC_BITS-1:0] scaled;
   logic [FRAC_BITS-1:0]             frac_idx;

   always_comb begin
      lead = '0;
      for (int i = 0; i < COUNT_WIDTH; i++) begin
         if (x[i]) begin
            lead = LOGK_WIDTH'(i);
         end
      end
   end

   assign rest     = x & ~(COUNT_WIDTH'(1) << lead);
   assign scaled   = {rest, {FRAC_BITS{1'b0}}} >> lead;
   assign frac_idx = scaled[FRAC_BITS-1:0];

   assign parts.k    = lead;
   assign parts.frac = (rest == '0) ? '0 : FRAC_LOG[frac_idx];

endmodule

// File: rtl/core/kld_accum.sv
// ----------------------------------------------------------------------------
// kld_accum: running sum and result register
// Adds one signed delta per beat; a last beat loads the result and clears.
// ----------------------------------------------------------------------------
module kld_accum
   import kld_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  beat_type                      beat,
   input  logic signed [DELTA_WIDTH-1:0] delta,
   output logic                          accept,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SUM_WIDTH-1:0]   rsp_divergence
);

   logic [SUM_WIDTH-1:0] sum_ff, sum_in, total;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_WIDTH-1:0] result_ff, result_in;
   logic                 out_free, take;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = beat.valid && (!beat.last || out_free);
   assign accept   = !beat.valid || take;
   assign total    = sum_ff + {{(SUM_WIDTH-DELTA_WIDTH){delta[DELTA_WIDTH-1]}}, delta};

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (take) begin
         if (beat.last) begin
            sum_in       = '0;
            rsp_valid_in = 1'b1;
            result_in    = total;
         end else begin
            sum_in = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_divergence = $signed(result_ff);

endmodule

// File: rtl/core/fixed_point_kl_divergence.sv
// ----------------------------------------------------------------------------
// fixed_point_kl_divergence: streamed fixed-point KL divergence over bins
// Adds p*log2(p) - p*log2(q) per in-plane bin with p, q > 0; emits on last bin.
// ----------------------------------------------------------------------------
// A last bin moves through stages 1, 2 and 3, then into the result register on rsp.
// Throughput: one bin per cycle; the elastic pipeline only stalls
//   when a last bin reaches the accumulator while the result register is full.
// Reset: sum cleared, pipeline emptied, plane_mode = all, bin_count = 64.
// ----------------------------------------------------------------------------
module fixed_point_kl_divergence
   import kld_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [INDEX_WIDTH-1:0]      req_bin_index,
   input  logic [COUNT_WIDTH-1:0]      req_p_count,
   input  logic [COUNT_WIDTH-1:0]      req_q_count,
   input  logic                        req_last_bin,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SUM_WIDTH-1:0] rsp_divergence,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   // Stage 1: captured input beat
   typedef struct packed {
      logic [INDEX_WIDTH-1:0] bin_index;
      logic [COUNT_WIDTH-1:0] p;
      logic [COUNT_WIDTH-1:0] q;
      logic                   last;
   } s1_type;

   // Stage 2: decoded logs and the in-plane / nonzero decision
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] p;
      log_parts_type          lp;
      log_parts_type          lq;
      logic                   use_bin;
      logic                   last;
   } s2_type;

   // Stage 3: the two weighted log terms (zero for a skipped bin)
   typedef struct packed {
      logic [TERM_WIDTH-1:0] term_p;
      logic [TERM_WIDTH-1:0] term_q;
      logic                  last;
   } s3_type;

   // ---------------- configuration registers ----------------
   logic [PLANE_WIDTH-1:0] plane_mode_ff, plane_mode_in;
   logic [BINS_WIDTH-1:0]  bin_count_ff, bin_count_in;

   always_comb begin
      plane_mode_in = plane_mode_ff;
      bin_count_in  = bin_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PLANE_MODE: plane_mode_in = csr_write_data[PLANE_WIDTH-1:0];
            CSR_BIN_COUNT:  bin_count_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_mode_ff <= PLANE_ALL;
         bin_count_ff  <= BIN_COUNT_RESET;
      end else begin
         plane_mode_ff <= plane_mode_in;
         bin_count_ff  <= bin_count_in;
      end
   end

   // ---------------- pipeline handshake ----------------
   // Each stage moves forward when the one after it has room this cycle.
   logic   s1_valid_ff, s1_valid_in, s1_ready;
   logic   s2_valid_ff, s2_valid_in, s2_ready;
   logic   s3_valid_ff, s3_valid_in, s3_ready;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // ---------------- stage 1 -> 2: log decode and plane test ----------------
   log_parts_type          lp_w, lq_w;
   logic [BINS_WIDTH-1:0]  count_eff, mean, idx_ext;
   logic                   in_plane;

   kld_log_decode u_log_p (.x(s1_ff.p), .parts(lp_w));
   kld_log_decode u_log_q (.x(s1_ff.q), .parts(lq_w));

   assign count_eff = (bin_count_ff > MAX_BINS) ? MAX_BINS : bin_count_ff;
   assign mean      = count_eff >> 1;
   assign idx_ext   = BINS_WIDTH'(s1_ff.bin_index);

   always_comb begin
      case (plane_mode_ff)
         PLANE_LEFT:  in_plane = idx_ext <= mean;
         PLANE_RIGHT: in_plane = (idx_ext >= mean) && (idx_ext < count_eff);
         default:     in_plane = idx_ext < count_eff;   // mode three acts as all
      endcase
   end

   // ---------------- stage 2 -> 3: weighted terms ----------------
   logic [LOGK_WIDTH+COUNT_WIDTH-1:0] pk_p, pk_q;
   logic [FRAC_WIDTH+COUNT_WIDTH-1:0] pf_p, pf_q;

   assign pk_p = (LOGK_WIDTH+COUNT_WIDTH)'(s2_ff.p) * (LOGK_WIDTH+COUNT_WIDTH)'(s2_ff.lp.k);
   assign pk_q = (LOGK_WIDTH+COUNT_WIDTH)'(s2_ff.p) * (LOGK_WIDTH+COUNT_WIDTH)'(s2_ff.lq.k);
   assign pf_p = (FRAC_WIDTH+COUNT_WIDTH)'(s2_ff.p) * (FRAC_WIDTH+COUNT_WIDTH)'(s2_ff.lp.frac);
   assign pf_q = (FRAC_WIDTH+COUNT_WIDTH)'(s2_ff.p) * (FRAC_WIDTH+COUNT_WIDTH)'(s2_ff.lq.frac);

   // ---------------- stage 3 -> accumulator ----------------
   logic signed [DELTA_WIDTH-1:0] delta;
   beat_type                      s3_beat;

   assign delta         = $signed({1'b0, s3_ff.term_p}) - $signed({1'b0, s3_ff.term_q});
   assign s3_beat.valid = s3_valid_ff;
   assign s3_beat.last  = s3_ff.last;

   kld_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .beat           (s3_beat),
      .delta          (delta),
      .accept         (s3_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_divergence (rsp_divergence)
   );

   // ---------------- stage next-state ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff && !s2_ready;
      s1_in       = s1_ff;
      if (req_valid && s1_ready) begin
         s1_valid_in     = 1'b1;
         s1_in.bin_index = req_bin_index;
         s1_in.p         = req_p_count;
         s1_in.q         = req_q_count;
         s1_in.last      = req_last_bin;
      end

      s2_valid_in = s2_valid_ff && !s3_ready;
      s2_in       = s2_ff;
      if (s1_valid_ff && s2_ready) begin
         s2_valid_in   = 1'b1;
         s2_in.p       = s1_ff.p;
         s2_in.lp      = lp_w;
         s2_in.lq      = lq_w;
         s2_in.use_bin = in_plane && (s1_ff.p != '0) && (s1_ff.q != '0);
         s2_in.last    = s1_ff.last;
      end

      s3_valid_in = s3_valid_ff && !s3_ready;
      s3_in       = s3_ff;
      if (s2_valid_ff && s3_ready) begin
         s3_valid_in = 1'b1;
         s3_in.last  = s2_ff.last;
         if (s2_ff.use_bin) begin
            s3_in.term_p = TERM_WIDTH'(pk_p) + TERM_WIDTH'(pf_p[FRAC_SHIFT +: COUNT_WIDTH]);
            s3_in.term_q = TERM_WIDTH'(pk_q) + TERM_WIDTH'(pf_q[FRAC_SHIFT +: COUNT_WIDTH]);
         end else begin
            s3_in.term_p = '0;
            s3_in.term_q = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   // ---------------- assertions ----------------
   // an accepted beat always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted beat did not enter stage 1");

   // a stalled stage 2 beat is not dropped
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_ready) |=> s2_valid_ff)
      else $error("stage 2 beat lost while stalled");

   // a last bin cannot pass while an untaken result is pending
   a_last_blocked: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.last && rsp_valid && !rsp_ready) |-> !s3_ready)
      else $error("last bin overwrote pending result");

   // a result only appears after a last bin reached the accumulator
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s3_valid_ff && s3_ff.last))
      else $error("result without last bin");

endmodule
